FILE: hw/rtl/a2obb_pkg.sv
package a2obb_pkg;

  localparam int MatW       = 32;
  localparam int CfgW       = 64;
  localparam int NumCfgRegs = 6;
  localparam int CfgIdxW    = 3;
  localparam int VecW       = 32;
  localparam int HalfW      = 31;
  localparam int KindW      = 2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_M_R0_C01 = 3'd0,
    REG_M_R0_C23 = 3'd1,
    REG_M_R1_C01 = 3'd2,
    REG_M_R1_C23 = 3'd3,
    REG_M_R2_C01 = 3'd4,
    REG_M_R2_C23 = 3'd5
  } cfg_reg_e;

  typedef enum logic [KindW-1:0] {
    KIND_CENTER = 2'd0,
    KIND_AXIS_U = 2'd1,
    KIND_AXIS_V = 2'd2,
    KIND_AXIS_W = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_RUN,
    FR_DRAIN,
    FR_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CENTER,
    BK_SQUARE,
    BK_SUM,
    BK_SQRT,
    BK_DIV,
    BK_EMIT
  } back_state_e;

endpackage

FILE: hw/rtl/a2obb_front.sv
module a2obb_front #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [6*COORD_WIDTH-1:0] in_data_i,
  input  logic [a2obb_pkg::NumCfgRegs*a2obb_pkg::CfgW-1:0] mat_i,
  output logic                    push_valid_o,
  input  logic                    push_ready_i,
  output logic [12*(COORD_WIDTH+1)-1:0] push_data_o
);
  import a2obb_pkg::*;

  localparam int IW  = COORD_WIDTH + 1;
  localparam int PW  = MatW + IW;
  localparam int TW  = MatW + FRAC_BITS;
  localparam int SW  = ((PW > TW) ? PW : TW) + 2;
  localparam logic signed [SW-1:0] SatMax = {{(SW-IW+1){1'b0}}, {(IW-1){1'b1}}};
  localparam logic signed [SW-1:0] SatMin = ~SatMax;

  front_state_e state_q, state_d;
  logic [2:0] step_q, step_d;
  logic [2:0] pstep_q;
  logic       pvalid_q;

  logic signed [COORD_WIDTH-1:0] lo_q [3];
  logic signed [IW-1:0]          d_q  [3];
  logic signed [MatW-1:0]        m    [3][4];
  logic signed [MatW-1:0]        opa  [3];
  logic signed [IW-1:0]          opb  [3];
  logic signed [PW-1:0]          prod_q [3];
  logic signed [IW-1:0]          c0_q [3];
  logic signed [IW-1:0]          e_q  [3][3];

  logic        accept;
  logic        issue;
  logic [1:0]  row;
  logic [1:0]  axis;
  logic [1:0]  prow;
  logic [1:0]  paxis;
  logic signed [SW-1:0] acc;
  logic signed [IW-1:0] row_res;
  logic signed [IW-1:0] ax_res [3];

  function automatic logic signed [IW-1:0] sat_iw(input logic signed [SW-1:0] x);
    logic signed [IW-1:0] r;
    if (x > SatMax) begin
      r = SatMax[IW-1:0];
    end else if (x < SatMin) begin
      r = SatMin[IW-1:0];
    end else begin
      r = x[IW-1:0];
    end
    return r;
  endfunction

  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar c = 0; c < 4; c++) begin : g_col
      assign m[r][c] = mat_i[(r*2 + c/2)*CfgW + (c%2)*MatW +: MatW];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      FR_IDLE: begin
        if (in_valid_i) begin
          state_d = FR_RUN;
          step_d  = 3'd0;
        end
      end
      FR_RUN: begin
        if (step_q == 3'd5) begin
          state_d = FR_DRAIN;
        end else begin
          step_d = step_q + 3'd1;
        end
      end
      FR_DRAIN: state_d = FR_PUSH;
      FR_PUSH: begin
        if (push_ready_i) begin
          if (in_valid_i) begin
            state_d = FR_RUN;
            step_d  = 3'd0;
          end else begin
            state_d = FR_IDLE;
          end
        end
      end
      default: state_d = FR_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o   = 1'b0;
    push_valid_o = 1'b0;
    issue        = 1'b0;
    unique case (state_q)
      FR_IDLE:  in_ready_o = 1'b1;
      FR_RUN:   issue = 1'b1;
      FR_DRAIN: ;
      FR_PUSH: begin
        push_valid_o = 1'b1;
        in_ready_o   = push_ready_i;
      end
      default: ;
    endcase
  end

  assign accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= FR_IDLE;
      step_q   <= 3'd0;
      pstep_q  <= 3'd0;
      pvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      pstep_q  <= step_q;
      pvalid_q <= issue;
    end
  end

  // multiplier operands: steps 0..2 transform the min corner row by row,
  // steps 3..5 scale one matrix column by one box extent
  assign row  = step_q[1:0];
  assign axis = 2'(step_q - 3'd3);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (step_q < 3'd3) begin
        opa[i] = m[row][i];
        opb[i] = IW'(lo_q[i]);
      end else begin
        opa[i] = m[i][axis];
        opb[i] = d_q[axis];
      end
    end
  end

  assign prow  = pstep_q[1:0];
  assign paxis = 2'(pstep_q - 3'd3);

  always_comb begin
    acc = SW'(prod_q[0]) + SW'(prod_q[1]) + SW'(prod_q[2])
        + (SW'(m[prow][3]) <<< FRAC_BITS);
    row_res = sat_iw(acc >>> FRAC_BITS);
    for (int i = 0; i < 3; i++) begin
      ax_res[i] = sat_iw(SW'(prod_q[i]) >>> FRAC_BITS);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int i = 0; i < 3; i++) begin
        lo_q[i] <= in_data_i[i*COORD_WIDTH +: COORD_WIDTH];
        d_q[i]  <= IW'($signed(in_data_i[(i+3)*COORD_WIDTH +: COORD_WIDTH]))
                 - IW'($signed(in_data_i[i*COORD_WIDTH +: COORD_WIDTH]));
      end
    end
    if (issue) begin
      for (int i = 0; i < 3; i++) begin
        prod_q[i] <= opa[i] * opb[i];
      end
    end
    if (pvalid_q) begin
      if (pstep_q < 3'd3) begin
        c0_q[prow] <= row_res;
      end else begin
        for (int i = 0; i < 3; i++) begin
          e_q[paxis][i] <= ax_res[i];
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      push_data_o[i*IW +: IW] = c0_q[i];
      for (int a = 0; a < 3; a++) begin
        push_data_o[(3 + a*3 + i)*IW +: IW] = e_q[a][i];
      end
    end
  end

endmodule

FILE: hw/rtl/a2obb_fifo.sv
module a2obb_fifo #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output logic [WIDTH-1:0] rd_data_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wptr_q, rptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             push, pop;

  assign wr_ready_o = (cnt_q != CntW'(DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= (wptr_q == PtrW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= (rptr_q == PtrW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      cnt_q <= cnt_q + CntW'(push) - CntW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

endmodule

FILE: hw/rtl/a2obb_back.sv
module a2obb_back #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              pop_valid_i,
  output logic                              pop_ready_o,
  input  logic [12*(COORD_WIDTH+1)-1:0]     pop_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output a2obb_pkg::kind_e                  out_kind_o,
  output logic [a2obb_pkg::VecW-1:0]        out_vec_x_o,
  output logic [a2obb_pkg::VecW-1:0]        out_vec_y_o,
  output logic [a2obb_pkg::VecW-1:0]        out_vec_z_o,
  output logic [a2obb_pkg::HalfW-1:0]       out_half_o,
  output logic                              out_degen_o,
  output logic                              out_last_o
);
  import a2obb_pkg::*;

  localparam int IW   = COORD_WIDTH + 1;
  localparam int RW   = COORD_WIDTH + 2;
  localparam int SSW  = 2 * RW;
  localparam int SCW  = $clog2(RW);
  localparam int QW   = FRAC_BITS + 1;
  localparam int DCW  = $clog2(FRAC_BITS + 1);
  localparam int CEW  = (IW + 2 > VecW + 1) ? IW + 2 : VecW + 1;
  localparam int HW   = RW - 1;
  localparam int XW   = (HW > HalfW) ? HW : HalfW;
  localparam logic signed [CEW-1:0] CenMax = {{(CEW-VecW+1){1'b0}}, {(VecW-1){1'b1}}};
  localparam logic signed [CEW-1:0] CenMin = ~CenMax;
  localparam logic [XW-1:0]         HalfMax = XW'({HalfW{1'b1}});

  back_state_e state_q, state_d;
  logic [1:0]     ax_q;
  logic [SCW-1:0] scnt_q;
  logic [DCW-1:0] dcnt_q;
  logic           out_valid_q;
  logic           out_free;
  logic           load_center, load_axis;

  logic signed [IW-1:0] c0 [3];
  logic signed [IW-1:0] e  [3][3];
  logic signed [IW-1:0] ea [3];
  logic [IW-1:0]        emag [3];

  logic [2*IW-1:0] sq_q [3];
  logic [SSW-1:0]  rad_q;
  logic [RW+1:0]   rem_q;
  logic [RW-1:0]   root_q;
  logic [RW+3:0]   rem_sh, trial;
  logic [RW:0]     drem_q [3];
  logic [RW:0]     drn [3];
  logic            dbit [3];
  logic [QW-1:0]   q_q [3];

  logic signed [IW+1:0]  esum [3];
  logic signed [CEW-1:0] cen [3];
  logic [VecW-1:0]       cen_sat [3];
  logic [VecW-1:0]       dir [3];
  logic [XW-1:0]         half_x;

  kind_e            kind_q;
  logic [VecW-1:0]  vec_q [3];
  logic [HalfW-1:0] half_q;
  logic             degen_q, last_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c0[i] = pop_data_i[i*IW +: IW];
      for (int a = 0; a < 3; a++) begin
        e[a][i] = pop_data_i[(3 + a*3 + i)*IW +: IW];
      end
      ea[i]   = e[ax_q][i];
      emag[i] = ea[i][IW-1] ? IW'(-ea[i]) : IW'(ea[i]);
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE:   if (pop_valid_i) state_d = BK_CENTER;
      BK_CENTER: if (out_free) state_d = BK_SQUARE;
      BK_SQUARE: state_d = BK_SUM;
      BK_SUM:    state_d = BK_SQRT;
      BK_SQRT:   if (scnt_q == SCW'(RW - 1)) state_d = BK_DIV;
      BK_DIV:    if (dcnt_q == DCW'(FRAC_BITS)) state_d = BK_EMIT;
      BK_EMIT: begin
        if (out_free) begin
          state_d = (ax_q == 2'd2) ? BK_IDLE : BK_SQUARE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    load_center = 1'b0;
    load_axis   = 1'b0;
    pop_ready_o = 1'b0;
    unique case (state_q)
      BK_CENTER: load_center = out_free;
      BK_EMIT: begin
        load_axis   = out_free;
        pop_ready_o = out_free && (ax_q == 2'd2);
      end
      default: ;
    endcase
  end

  // centre: transformed min corner plus half the edge sum, floored
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      esum[i] = (IW+2)'(e[0][i]) + (IW+2)'(e[1][i]) + (IW+2)'(e[2][i]);
      cen[i]  = CEW'(c0[i]) + CEW'(esum[i] >>> 1);
      if (cen[i] > CenMax) begin
        cen_sat[i] = CenMax[VecW-1:0];
      end else if (cen[i] < CenMin) begin
        cen_sat[i] = CenMin[VecW-1:0];
      end else begin
        cen_sat[i] = cen[i][VecW-1:0];
      end
    end
  end

  // square root digit step
  assign rem_sh = {rem_q, rad_q[SSW-1 -: 2]};
  assign trial  = {2'b00, root_q, 2'b01};

  // restoring divide step, one quotient bit per cycle per lane
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      drn[i]  = (dcnt_q == '0) ? drem_q[i] : {drem_q[i][RW-1:0], 1'b0};
      dbit[i] = (drn[i] >= {1'b0, root_q});
      dir[i]  = ea[i][IW-1] ? VecW'(-$signed({1'b0, q_q[i]})) : VecW'(q_q[i]);
    end
  end

  assign half_x = XW'(root_q >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      ax_q        <= 2'd0;
      scnt_q      <= '0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_center) begin
        ax_q <= 2'd0;
      end else if (load_axis) begin
        ax_q <= ax_q + 2'd1;
      end
      if (state_q == BK_SUM) begin
        scnt_q <= '0;
      end else if (state_q == BK_SQRT) begin
        scnt_q <= scnt_q + 1'b1;
      end
      if (state_q == BK_SQRT) begin
        dcnt_q <= '0;
      end else if (state_q == BK_DIV) begin
        dcnt_q <= dcnt_q + 1'b1;
      end
      if (load_center || load_axis) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == BK_SQUARE) begin
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= emag[i] * emag[i];
      end
    end
    if (state_q == BK_SUM) begin
      rad_q  <= SSW'(sq_q[0]) + SSW'(sq_q[1]) + SSW'(sq_q[2]);
      rem_q  <= '0;
      root_q <= '0;
    end
    if (state_q == BK_SQRT) begin
      rad_q <= {rad_q[SSW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_q  <= (RW+2)'(rem_sh - trial);
        root_q <= {root_q[RW-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh[RW+1:0];
        root_q <= {root_q[RW-2:0], 1'b0};
      end
      for (int i = 0; i < 3; i++) begin
        drem_q[i] <= (RW+1)'(emag[i]);
        q_q[i]    <= '0;
      end
    end
    if (state_q == BK_DIV) begin
      for (int i = 0; i < 3; i++) begin
        drem_q[i] <= dbit[i] ? drn[i] - {1'b0, root_q} : drn[i];
        q_q[i]    <= {q_q[i][QW-2:0], dbit[i]};
      end
    end
    if (load_center) begin
      kind_q  <= KIND_CENTER;
      half_q  <= '0;
      degen_q <= 1'b0;
      last_q  <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        vec_q[i] <= cen_sat[i];
      end
    end else if (load_axis) begin
      unique case (ax_q)
        2'd0:    kind_q <= KIND_AXIS_U;
        2'd1:    kind_q <= KIND_AXIS_V;
        default: kind_q <= KIND_AXIS_W;
      endcase
      half_q  <= (half_x > HalfMax) ? HalfMax[HalfW-1:0] : half_x[HalfW-1:0];
      degen_q <= (root_q == '0);
      last_q  <= (ax_q == 2'd2);
      for (int i = 0; i < 3; i++) begin
        vec_q[i] <= (root_q == '0) ? '0 : dir[i];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = kind_q;
  assign out_vec_x_o = vec_q[0];
  assign out_vec_y_o = vec_q[1];
  assign out_vec_z_o = vec_q[2];
  assign out_half_o  = half_q;
  assign out_degen_o = degen_q;
  assign out_last_o  = last_q;

endmodule

FILE: hw/rtl/aabb_to_obb_transform.sv
// The front end computes the box's matrix products, then the back end handles the centre
//   and each axis in turn; a new box can enter the front end while the back end still
//   works on earlier ones, with the pace set by the bit-serial square root and the
//   one-bit-per-cycle dividers.
// Reset: asynchronous, active low; clears all control and loads the identity matrix.
module aabb_to_obb_transform #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic clk_i,
  input  logic rst_ni,

  // box corners, from bit 0 up: min_x, min_y, min_z, max_x, max_y, max_z
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]      s_axis_tdata,

  // from bit 0 up: vec_x, vec_y, vec_z, half_extent, degenerate
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  output logic [127:0]                            m_axis_tdata,
  // kind
  output logic [a2obb_pkg::KindW-1:0]             m_axis_tuser,
  output logic                                    m_axis_tlast,

  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [a2obb_pkg::CfgIdxW-1:0]           cfg_index_i,
  input  logic [a2obb_pkg::CfgW-1:0]              cfg_data_i
);
  import a2obb_pkg::*;

  localparam int IW  = COORD_WIDTH + 1;
  localparam int QDW = 12 * IW;

  // matrix registers: rows of two Q16.16 entries per transaction
  logic [CfgW-1:0] cfg_q [NumCfgRegs];
  logic [NumCfgRegs*CfgW-1:0] mat;

  // front end -> queue -> back end
  logic           fr_valid, fr_ready;
  logic [QDW-1:0] fr_data;
  logic           bk_valid, bk_ready;
  logic [QDW-1:0] bk_data;

  kind_e            kind;
  logic [VecW-1:0]  vec_x, vec_y, vec_z;
  logic [HalfW-1:0] half;
  logic             degen;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q[REG_M_R0_C01] <= 64'h0000_0000_0001_0000;
      cfg_q[REG_M_R0_C23] <= 64'h0;
      cfg_q[REG_M_R1_C01] <= 64'h0001_0000_0000_0000;
      cfg_q[REG_M_R1_C23] <= 64'h0;
      cfg_q[REG_M_R2_C01] <= 64'h0;
      cfg_q[REG_M_R2_C23] <= 64'h0000_0000_0001_0000;
    end else if (cfg_valid_i && (cfg_index_i <= REG_M_R2_C23)) begin
      // indexes past the last register are dropped
      cfg_q[cfg_index_i] <= cfg_data_i;
    end
  end

  for (genvar r = 0; r < NumCfgRegs; r++) begin : g_mat
    assign mat[r*CfgW +: CfgW] = cfg_q[r];
  end

  // front end: takes the box, runs the 18 matrix products three at a time
  a2obb_front #(
    .COORD_WIDTH(COORD_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata[6*COORD_WIDTH-1:0]),
    .mat_i       (mat),
    .push_valid_o(fr_valid),
    .push_ready_i(fr_ready),
    .push_data_o (fr_data)
  );

  // two entries so the front end keeps working while the back end grinds
  a2obb_fifo #(
    .WIDTH(QDW),
    .DEPTH(2)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(fr_valid),
    .wr_ready_o(fr_ready),
    .wr_data_i (fr_data),
    .rd_valid_o(bk_valid),
    .rd_ready_i(bk_ready),
    .rd_data_o (bk_data)
  );

  // back end: centre, then per axis square root and normalisation
  a2obb_back #(
    .COORD_WIDTH(COORD_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_valid_i(bk_valid),
    .pop_ready_o(bk_ready),
    .pop_data_i (bk_data),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_kind_o (kind),
    .out_vec_x_o(vec_x),
    .out_vec_y_o(vec_y),
    .out_vec_z_o(vec_z),
    .out_half_o (half),
    .out_degen_o(degen),
    .out_last_o (m_axis_tlast)
  );

  assign m_axis_tdata = {degen, half, vec_z, vec_y, vec_x};
  assign m_axis_tuser = kind;

endmodule
